>>> hdl/cartridge_bank_controller_assert.svh
// assertion macros shared by cbc_rem_unit and cartridge_bank_controller
// expects aclk and aresetn in the scope of every use
`ifndef CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH

// same-cycle implication, ignored while reset is applied
`define CBC_ASSERT_HOLDS(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while reset is applied
`define CBC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/cbc_pkg.sv
// shared types, codes and helper functions for the cartridge bank controller
// no dependencies
package cbc_pkg;

    // controller kinds
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_MBC1 = 3'd1;
    localparam logic [2:0] KIND_MBC2 = 3'd2;
    localparam logic [2:0] KIND_MBC3 = 3'd3;
    localparam logic [2:0] KIND_MBC5 = 3'd4;

    // result targets
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_ROM  = 2'd1;
    localparam logic [1:0] TGT_RAM  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE  = 2'd3;
    localparam int CFG_DATA_W = 10;

    // bank geometry
    localparam int ROM_BANK_W    = 9;
    localparam int RAM_BANK_W    = 4;
    localparam int ROM_COUNT_W   = 10;
    localparam int MAX_ROM_BANKS = 512;
    localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;

    // bank register state seen by the mapping logic
    typedef struct packed {
        logic                  ram_enable;
        logic [ROM_BANK_W-1:0] rom_bank;
        logic [RAM_BANK_W-1:0] ram_bank;
        logic                  mode;
    } bank_state_t;

    // unknown kinds behave as no controller
    function automatic logic [2:0] kind_now(input logic [2:0] kind);
        return (kind > KIND_MBC5) ? KIND_NONE : kind;
    endfunction

    // number of 8 KiB RAM banks that fit in the RAM size code
    function automatic logic [4:0] ram_bank_limit(input logic [2:0] code);
        logic [4:0] lim;
        case (code)
            3'd1:    lim = 5'd1;
            3'd2:    lim = 5'd1;
            3'd3:    lim = 5'd4;
            3'd4:    lim = 5'd16;
            3'd5:    lim = 5'd8;
            default: lim = 5'd0;
        endcase
        return lim;
    endfunction

endpackage

>>> hdl/cbc_rem_unit.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on cbc_pkg and cartridge_bank_controller_assert.svh
`include "cartridge_bank_controller_assert.svh"

module cbc_rem_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [cbc_pkg::ROM_BANK_W-1:0] dividend,
    input  logic [cbc_pkg::ROM_COUNT_W-1:0] divisor,
    output logic                           busy,
    output logic                           done,
    output logic [cbc_pkg::ROM_COUNT_W-1:0] remainder
);
    import cbc_pkg::*;

    localparam int CNT_W = $clog2(ROM_BANK_W + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [ROM_BANK_W-1:0]  dvd_reg, dvd_next;
    logic [ROM_COUNT_W-1:0] dvs_reg, dvs_next;
    logic [ROM_COUNT_W-1:0] rem_reg, rem_next;

    logic [ROM_COUNT_W:0]   rem_shift;
    logic [ROM_COUNT_W:0]   rem_step;

    // one shift-compare-subtract step
    always_comb begin
        rem_shift = {rem_reg, dvd_reg[ROM_BANK_W-1]};
        if (rem_shift >= {1'b0, dvs_reg}) begin
            rem_step = rem_shift - {1'b0, dvs_reg};
        end else begin
            rem_step = rem_shift;
        end
    end

    // step sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(ROM_BANK_W);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = rem_step[ROM_COUNT_W-1:0];
            dvd_next = {dvd_reg[ROM_BANK_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath flops
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

    `CBC_ASSERT_NEXT(a_start_busy, start, busy_reg, "remainder unit did not start")
    `CBC_ASSERT_HOLDS(a_busy_done, busy_reg, !done_reg, "remainder unit busy and done")
    `CBC_ASSERT_HOLDS(a_rem_range, done_reg && (dvs_reg != '0), rem_reg < dvs_reg,
        "remainder not below divisor")

endmodule

>>> hdl/cbc_bank_regs.sv
// bank control registers written by cpu writes below 0x8000
// depends on cbc_pkg
module cbc_bank_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [2:0]           kind,
    input  logic [15:0]          addr,
    input  logic [7:0]           data,
    output cbc_pkg::bank_state_t bank
);
    import cbc_pkg::*;

    bank_state_t bank_reg, bank_next;

    // register write decode per controller kind
    always_comb begin
        bank_next = bank_reg;
        if (wr_en && (kind != KIND_NONE)) begin
            case (addr[14:13])
                2'd0: begin
                    if ((kind != KIND_MBC2) || !addr[8]) begin
                        bank_next.ram_enable = (data == RAM_ENABLE_KEY);
                    end
                end
                2'd1: begin
                    case (kind)
                        KIND_MBC1: bank_next.rom_bank = {2'd0, bank_reg.rom_bank[6:5], data[4:0]};
                        KIND_MBC2: begin
                            if (addr[8]) begin
                                bank_next.rom_bank = {5'd0, data[3:0]};
                            end
                        end
                        KIND_MBC3: bank_next.rom_bank = {2'd0, data[6:0]};
                        default: begin
                            if (!addr[12]) begin
                                bank_next.rom_bank = {bank_reg.rom_bank[8], data};
                            end else begin
                                bank_next.rom_bank = {data[0], bank_reg.rom_bank[7:0]};
                            end
                        end
                    endcase
                end
                2'd2: begin
                    if (kind == KIND_MBC1) begin
                        bank_next.rom_bank = {2'd0, data[1:0], bank_reg.rom_bank[4:0]};
                    end else if ((kind == KIND_MBC3) || (kind == KIND_MBC5)) begin
                        bank_next.ram_bank = data[3:0];
                    end
                end
                default: begin
                    if (kind == KIND_MBC1) begin
                        bank_next.mode     = data[0];
                        bank_next.rom_bank = {4'd0, bank_reg.rom_bank[4:0]};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg.ram_enable <= 1'b1;
            bank_reg.rom_bank   <= ROM_BANK_W'(1);
            bank_reg.ram_bank   <= '0;
            bank_reg.mode       <= 1'b0;
        end else begin
            bank_reg <= bank_next;
        end
    end

    assign bank = bank_reg;

endmodule

>>> hdl/cartridge_bank_controller.sv
// cartridge bank controller: the result is loaded when the 9-step serial remainder
// unit that reduces the mbc1 rom bank is done and the result register is free;
// no new input beat is taken until that result is loaded
// reset: bank registers to ram enabled, rom bank 1, ram bank 0, mode 0;
// configuration to no controller, no banked ram, 2 rom banks, no ram
// depends on cbc_pkg, cbc_rem_unit, cbc_bank_regs, cartridge_bank_controller_assert.svh
`include "cartridge_bank_controller_assert.svh"

module cartridge_bank_controller (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]      cfg_data,
    // access channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [15:0]                         s_address,
    input  logic [7:0]                          s_write_data,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_target,
    output logic [22:0]                         m_mem_offset,
    output logic                                m_store_enable,
    output logic [7:0]                          m_store_value
);
    import cbc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [2:0]             kind_reg;
    logic                   ram_banks_reg;
    logic [ROM_COUNT_W-1:0] rom_count_reg;
    logic [2:0]             ram_size_reg;

    // latched request
    logic                   req_write_reg;
    logic [15:0]            req_addr_reg;
    logic [7:0]             req_data_reg;

    // result register
    logic                   m_valid_reg, m_valid_next;
    logic [1:0]             m_target_reg, m_target_next;
    logic [22:0]            m_offset_reg, m_offset_next;
    logic                   m_store_reg, m_store_next;
    logic [7:0]             m_value_reg, m_value_next;

    logic                   in_beat;
    logic                   out_free;
    logic                   load_out;
    logic [2:0]             kind_n;
    logic [ROM_COUNT_W-1:0] count_clamp;
    bank_state_t            bank;
    logic [ROM_BANK_W-1:0]  mbc1_bank;
    logic [ROM_BANK_W-1:0]  plain_bank;
    logic [ROM_BANK_W-1:0]  rom_sel;
    logic                   ram_ok;
    logic [RAM_BANK_W-1:0]  ram_sel;
    logic [4:0]             ram_lim;
    logic                   rem_busy;
    logic                   rem_done;
    logic [ROM_COUNT_W-1:0] rem_value;

    assign cfg_ready = 1'b1;
    assign in_beat   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign kind_n    = kind_now(kind_reg);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg      <= KIND_NONE;
            ram_banks_reg <= 1'b0;
            rom_count_reg <= ROM_COUNT_W'(2);
            ram_size_reg  <= 3'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_KIND:      kind_reg      <= cfg_data[2:0];
                CFG_RAM_BANKS: ram_banks_reg <= cfg_data[0];
                CFG_ROM_COUNT: rom_count_reg <= cfg_data;
                CFG_RAM_SIZE:  ram_size_reg  <= cfg_data[2:0];
                default:       kind_reg      <= kind_reg;
            endcase
        end
    end

    // bank registers take cpu writes below 0x8000 on the input beat
    cbc_bank_regs u_bank_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (in_beat && s_req_type && !s_address[15]),
        .kind    (kind_n),
        .addr    (s_address),
        .data    (s_write_data),
        .bank    (bank)
    );

    // mbc1 bank before reduction: low five bits of zero step to one
    always_comb begin
        if (!bank.mode) begin
            mbc1_bank = {2'd0, bank.rom_bank[6:0]};
        end else begin
            mbc1_bank = {4'd0, bank.rom_bank[4:0]};
        end
        if (bank.rom_bank[4:0] == 5'd0) begin
            mbc1_bank[0] = 1'b1;
        end
    end

    assign count_clamp = (rom_count_reg > ROM_COUNT_W'(MAX_ROM_BANKS)) ?
                         ROM_COUNT_W'(MAX_ROM_BANKS) : rom_count_reg;

    // shared remainder unit, started on every input beat
    cbc_rem_unit u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (in_beat),
        .dividend  (mbc1_bank),
        .divisor   (count_clamp),
        .busy      (rem_busy),
        .done      (rem_done),
        .remainder (rem_value)
    );

    // switched rom bank
    always_comb begin
        case (kind_n)
            KIND_MBC2, KIND_MBC3: plain_bank = (bank.rom_bank == '0) ?
                                               ROM_BANK_W'(1) : bank.rom_bank;
            KIND_MBC5:            plain_bank = bank.rom_bank;
            default:              plain_bank = ROM_BANK_W'(1);
        endcase
        if (count_clamp == '0) begin
            rom_sel = '0;
        end else if (kind_n == KIND_MBC1) begin
            rom_sel = rem_value[ROM_BANK_W-1:0];
        end else if ({1'b0, plain_bank} >= count_clamp) begin
            rom_sel = '0;
        end else begin
            rom_sel = plain_bank;
        end
    end

    // switched ram bank
    always_comb begin
        ram_ok  = (kind_n != KIND_NONE);
        ram_sel = '0;
        ram_lim = ram_bank_limit(ram_size_reg);
        if (ram_banks_reg) begin
            case (kind_n)
                KIND_MBC1: ram_sel = bank.mode ? {2'd0, bank.rom_bank[6:5]} : '0;
                KIND_MBC3: begin
                    ram_ok  = (bank.ram_bank <= RAM_BANK_W'(3));
                    ram_sel = bank.ram_bank;
                end
                KIND_MBC5: ram_sel = bank.ram_bank;
                default:   ram_sel = '0;
            endcase
        end
        if ({1'b0, ram_sel} >= ram_lim) begin
            ram_sel = '0;
        end
    end

    // result formation
    always_comb begin
        m_target_next = TGT_NONE;
        m_offset_next = '0;
        m_store_next  = 1'b0;
        m_value_next  = '0;
        if (!req_addr_reg[15]) begin
            if (!req_write_reg) begin
                m_target_next = TGT_ROM;
                if (!req_addr_reg[14]) begin
                    m_offset_next = {7'd0, req_addr_reg};
                end else begin
                    m_offset_next = {rom_sel, req_addr_reg[13:0]};
                end
            end
        end else if ((req_addr_reg[14:13] == 2'b01) && ram_ok) begin
            if (!req_write_reg) begin
                m_target_next = TGT_RAM;
                m_offset_next = {6'd0, ram_sel, req_addr_reg[12:0]};
            end else if (bank.ram_enable && (ram_lim != '0)) begin
                m_target_next = TGT_RAM;
                m_offset_next = {6'd0, ram_sel, req_addr_reg[12:0]};
                m_store_next  = 1'b1;
                m_value_next  = (kind_n == KIND_MBC2) ? {4'd0, req_data_reg[3:0]} :
                                req_data_reg;
            end
        end
    end

    // sequencer
    assign load_out = (state_reg == S_RUN) && rem_done && out_free;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (load_out) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            req_write_reg <= s_req_type;
            req_addr_reg  <= s_address;
            req_data_reg  <= s_write_data;
        end
        if (load_out) begin
            m_target_reg <= m_target_next;
            m_offset_reg <= m_offset_next;
            m_store_reg  <= m_store_next;
            m_value_reg  <= m_value_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_target       = m_target_reg;
    assign m_mem_offset   = m_offset_reg;
    assign m_store_enable = m_store_reg;
    assign m_store_value  = m_value_reg;

    `CBC_ASSERT_NEXT(a_beat_runs, in_beat, (state_reg == S_RUN) && rem_busy,
        "input beat did not start the sequencer")
    `CBC_ASSERT_HOLDS(a_store_ram, m_valid_reg && m_store_reg, m_target_reg == TGT_RAM,
        "store enable outside cartridge ram")
    `CBC_ASSERT_HOLDS(a_none_zero, m_valid_reg && (m_target_reg == TGT_NONE),
        (m_offset_reg == '0) && !m_store_reg, "no-target result carries offset or store")

endmodule

>>> tb/sv/tb_cartridge_bank_controller.sv
// self-checking bench for cartridge_bank_controller: bus accesses and bank setups
// go in, every result beat is compared against a scoreboard that maps the access
// depends on cbc_pkg and the cartridge_bank_controller rtl
`timescale 1ns / 100ps

module tb_cartridge_bank_controller;
    import cbc_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int RANDOM_PHASES  = 18;
    localparam int PHASE_ACCESSES = 80;
    localparam int MAX_PRINTS     = 40;

    localparam logic BUS_READ  = 1'b0;
    localparam logic BUS_WRITE = 1'b1;

    // kinds past mbc5 that must act as no controller
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // ram size codes used by the bench
    localparam logic [2:0] RAM_CODE_NONE  = 3'd0;
    localparam logic [2:0] RAM_CODE_2K    = 3'd1;
    localparam logic [2:0] RAM_CODE_32K   = 3'd3;
    localparam logic [2:0] RAM_CODE_128K  = 3'd4;
    localparam logic [2:0] RAM_CODE_64K   = 3'd5;
    localparam logic [2:0] RAM_CODE_SPARE = 3'd6;

    typedef struct packed {
        logic [1:0]  target;
        logic [22:0] mem_offset;
        logic        store_enable;
        logic [7:0]  store_value;
    } bank_result_t;

    // mirror of the bank registers plus the queue of results still owed
    class bank_map_scoreboard;
        logic [2:0]  kind;
        logic        ram_banked;
        logic [9:0]  rom_count;
        logic [2:0]  ram_code;
        logic        ram_on;
        logic [8:0]  rom_bank;
        logic [3:0]  ram_bank;
        logic        mode;
        bank_result_t owed_results[$];
        int unsigned errors;
        int unsigned results_checked;

        function new();
            kind = KIND_NONE;
            ram_banked = 1'b0;
            rom_count = 10'd2;
            ram_code = RAM_CODE_NONE;
            ram_on = 1'b1;
            rom_bank = 9'd1;
            ram_bank = 4'd0;
            mode = 1'b0;
            errors = 0;
            results_checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_KIND:      kind = val[2:0];
                CFG_RAM_BANKS: ram_banked = val[0];
                CFG_ROM_COUNT: rom_count = val[9:0];
                CFG_RAM_SIZE:  ram_code = val[2:0];
                default: ;
            endcase
        endfunction

        function int unsigned ram_bytes(logic [2:0] code);
            case (code)
                RAM_CODE_2K:   return 2048;
                3'd2:          return 8192;
                RAM_CODE_32K:  return 32768;
                RAM_CODE_128K: return 131072;
                RAM_CODE_64K:  return 65536;
                default:       return 0;
            endcase
        endfunction

        // bank seen in the 0x4000 window
        function int unsigned rom_window_bank(logic [2:0] k);
            int unsigned cnt;
            int unsigned b;
            cnt = (rom_count > MAX_ROM_BANKS) ? MAX_ROM_BANKS : rom_count;
            if (cnt == 0)
                return 0;
            case (k)
                KIND_MBC1: begin
                    if (!mode) begin
                        // low five bits zero means 0x00, 0x20, 0x40 or 0x60
                        b = rom_bank[6:0];
                        if (rom_bank[4:0] == 5'd0)
                            b = b + 1;
                    end else begin
                        b = rom_bank[4:0];
                        if (b == 0)
                            b = 1;
                    end
                    b = b % cnt;
                end
                KIND_MBC2, KIND_MBC3: begin
                    b = rom_bank;
                    if (b == 0)
                        b = 1;
                end
                KIND_MBC5: b = rom_bank;
                default:   b = 1;
            endcase
            return (b >= cnt) ? 0 : b;
        endfunction

        // ram bank in the 0xa000 window, zero return when nothing is mapped
        function bit ram_window_bank(logic [2:0] k, output int unsigned b);
            b = 0;
            if (k == KIND_NONE)
                return 1'b0;
            if (ram_banked) begin
                case (k)
                    KIND_MBC1: b = mode ? rom_bank[6:5] : 0;
                    KIND_MBC3: begin
                        if (ram_bank > 4'd3)
                            return 1'b0;
                        b = ram_bank;
                    end
                    KIND_MBC5: b = ram_bank;
                    default: ;
                endcase
            end
            if (b * 'h2000 >= ram_bytes(ram_code))
                b = 0;
            return 1'b1;
        endfunction

        // writes below 0x8000 land in the bank registers
        function void bank_write(logic [2:0] k, logic [15:0] addr, logic [7:0] v);
            if (k == KIND_NONE)
                return;
            if (addr <= 16'h1fff) begin
                if (k != KIND_MBC2 || !addr[8])
                    ram_on = (v == RAM_ENABLE_KEY);
            end else if (addr <= 16'h3fff) begin
                case (k)
                    KIND_MBC1: rom_bank = {2'b00, rom_bank[6:5], v[4:0]};
                    KIND_MBC2: begin
                        if (addr[8])
                            rom_bank = {5'd0, v[3:0]};
                    end
                    KIND_MBC3: rom_bank = {2'b00, v[6:0]};
                    KIND_MBC5: begin
                        if (addr <= 16'h2fff)
                            rom_bank = {rom_bank[8], v};
                        else
                            rom_bank = {v[0], rom_bank[7:0]};
                    end
                    default: ;
                endcase
            end else if (addr <= 16'h5fff) begin
                if (k == KIND_MBC1)
                    rom_bank = {2'b00, v[1:0], rom_bank[4:0]};
                else if (k == KIND_MBC3 || k == KIND_MBC5)
                    ram_bank = v[3:0];
            end else if (k == KIND_MBC1) begin
                mode = v[0];
                rom_bank = {4'd0, rom_bank[4:0]};
            end
        endfunction

        function void note_access(logic wr, logic [15:0] addr, logic [7:0] data);
            bank_result_t r;
            logic [2:0] k;
            int unsigned b;
            int unsigned off;
            r = '0;
            k = (kind > KIND_MBC5) ? KIND_NONE : kind;
            if (addr <= 16'h7fff) begin
                if (wr)
                    bank_write(k, addr, data);
                else if (addr <= 16'h3fff) begin
                    r.target = TGT_ROM;
                    r.mem_offset = {7'd0, addr};
                end else begin
                    off = rom_window_bank(k) * 'h4000 + addr - 'h4000;
                    r.target = TGT_ROM;
                    r.mem_offset = off[22:0];
                end
            end else if (addr >= 16'ha000 && addr <= 16'hbfff) begin
                if (ram_window_bank(k, b)) begin
                    off = b * 'h2000 + addr - 'ha000;
                    if (!wr) begin
                        r.target = TGT_RAM;
                        r.mem_offset = off[22:0];
                    end else if (ram_on && ram_bytes(ram_code) != 0) begin
                        r.target = TGT_RAM;
                        r.mem_offset = off[22:0];
                        r.store_enable = 1'b1;
                        r.store_value = (k == KIND_MBC2) ? {4'd0, data[3:0]} : data;
                    end
                end
            end
            owed_results.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch at result beat %0d: %s got 0x%0h want 0x%0h",
                         results_checked, what, got, want);
        endtask

        task check_result(logic [1:0] target, logic [22:0] offset, logic store_en,
                          logic [7:0] store_val);
            bank_result_t want;
            if (owed_results.size() == 0) begin
                report("result beat with nothing outstanding, target", target, 0);
                return;
            end
            want = owed_results.pop_front();
            if (target !== want.target)
                report("target", target, want.target);
            if (offset !== want.mem_offset)
                report("mem_offset", offset, want.mem_offset);
            if (store_en !== want.store_enable)
                report("store_enable", store_en, want.store_enable);
            if (store_val !== want.store_value)
                report("store_value", store_val, want.store_value);
            results_checked++;
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_req_type;
    logic [15:0]            s_address;
    logic [7:0]             s_write_data;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_target;
    logic [22:0]            m_mem_offset;
    logic                   m_store_enable;
    logic [7:0]             m_store_value;

    bank_map_scoreboard sb;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          squeeze_request = 1'b0;
    int unsigned accesses_sent = 0;
    int unsigned bank_setups = 0;
    int unsigned cycles = 0;

    cartridge_bank_controller i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_address      (s_address),
        .s_write_data   (s_write_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_target       (m_target),
        .m_mem_offset   (m_mem_offset),
        .m_store_enable (m_store_enable),
        .m_store_value  (m_store_value)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_cartridge_bank_controller: errors");
            $finish;
        end
    end

    // result side ready, with one long hold-off on request
    always begin
        @(negedge aclk);
        if (squeeze_request) begin
            m_ready = 1'b0;
            squeeze_request = 1'b0;
            repeat (SQUEEZE_CYCLES) @(negedge aclk);
        end
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result beat
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_target, m_mem_offset, m_store_enable, m_store_value);
    end

    // one access beat, with random idle cycles in front
    task automatic send_access(logic wr, logic [15:0] addr, logic [7:0] data);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_req_type = wr;
        s_address = addr;
        s_write_data = data;
        do @(posedge aclk); while (!s_ready);
        sb.note_access(wr, addr, data);
        accesses_sent++;
    endtask

    // drop the access channel and wait for every owed result
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.owed_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [2:0] kind, logic banked, logic [9:0] count,
                             logic [2:0] code);
        settle();
        write_reg(CFG_KIND, CFG_DATA_W'(kind));
        write_reg(CFG_RAM_BANKS, CFG_DATA_W'(banked));
        write_reg(CFG_ROM_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_RAM_SIZE, CFG_DATA_W'(code));
        bank_setups++;
    endtask

    // bank writes, rom and ram window traffic, some anything-goes beats
    task automatic random_access();
        int unsigned pick;
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
        pick = $urandom_range(99);
        wr = 1'($urandom_range(1));
        addr = 16'($urandom_range(16'hffff));
        data = 8'($urandom_range(255));
        if (pick < 18) begin
            wr = BUS_WRITE;
            addr = 16'($urandom_range(16'h7fff));
            if (addr < 16'h2000 && $urandom_range(1))
                data = RAM_ENABLE_KEY;
        end else if (pick < 50) begin
            wr = BUS_READ;
            addr = $urandom_range(1) ? 16'($urandom_range(16'h7fff, 16'h4000))
                                     : 16'($urandom_range(16'h3fff));
        end else if (pick < 85) begin
            addr = 16'($urandom_range(16'hbfff, 16'ha000));
        end
        send_access(wr, addr, data);
    endtask

    task automatic run_directed();
        // mbc1: enable, bank zero remap, mode routing of the upper bits
        configure(KIND_MBC1, 1'b1, 10'd64, RAM_CODE_32K);
        send_access(BUS_WRITE, 16'h0000, RAM_ENABLE_KEY);
        send_access(BUS_WRITE, 16'h2000, 8'h00);
        send_access(BUS_WRITE, 16'h6000, 8'h01);
        send_access(BUS_WRITE, 16'h5fff, 8'h02);
        send_access(BUS_READ,  16'h4000, 8'hff);
        send_access(BUS_READ,  16'ha000, 8'h00);
        send_access(BUS_WRITE, 16'hbfff, 8'hff);
        send_access(BUS_WRITE, 16'h6000, 8'h00);
        send_access(BUS_WRITE, 16'h4000, 8'h03);
        send_access(BUS_READ,  16'h7fff, 8'h00);
        // ram disabled, write dropped
        send_access(BUS_WRITE, 16'h1fff, 8'h00);
        send_access(BUS_WRITE, 16'ha123, 8'h5a);
        send_access(BUS_READ,  16'h0000, 8'h00);
        send_access(BUS_READ,  16'h3fff, 8'h00);
        send_access(BUS_READ,  16'h8000, 8'h00);
        send_access(BUS_WRITE, 16'hffff, 8'hff);
        // mbc3 ram bank above 3 has no target
        configure(KIND_MBC3, 1'b1, 10'd128, RAM_CODE_128K);
        send_access(BUS_WRITE, 16'h4000, 8'h05);
        send_access(BUS_READ,  16'ha000, 8'h00);
        // mbc2 selector bit and nibble ram
        configure(KIND_MBC2, 1'b0, 10'd16, RAM_CODE_2K);
        send_access(BUS_WRITE, 16'h0000, RAM_ENABLE_KEY);
        send_access(BUS_WRITE, 16'h21ff, 8'hff);
        send_access(BUS_READ,  16'h4000, 8'h00);
        send_access(BUS_WRITE, 16'ha001, 8'hff);
        // mbc5 bank past the rom size falls back to bank 0
        configure(KIND_MBC5, 1'b1, 10'd2, RAM_CODE_64K);
        send_access(BUS_WRITE, 16'h3000, 8'h01);
        send_access(BUS_READ,  16'h4000, 8'h00);
        // spare kind, zero bank count, spare ram code
        configure(KIND_SPARE_HI, 1'b1, 10'd0, RAM_CODE_SPARE);
        send_access(BUS_READ,  16'h4000, 8'h00);
        send_access(BUS_READ,  16'ha000, 8'h00);
    endtask

    task automatic random_phase(int p);
        int unsigned sel;
        logic [2:0]  kind;
        logic        banked;
        logic [9:0]  count;
        logic [2:0]  code;
        sel = (p + 1) % 6;
        kind = (sel == 5) ? 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)) : 3'(sel);
        banked = 1'($urandom_range(1));
        code = 3'($urandom_range(7));
        case ($urandom_range(9))
            0:       count = 10'd2;
            1:       count = 10'd512;
            2:       count = 10'd0;
            3:       count = 10'd1;
            4:       count = 10'($urandom_range(1023, 513));
            5:       count = 10'($urandom_range(512, 2));
            default: count = 10'd1 << $urandom_range(9, 1);
        endcase
        // pin the extremes early on
        if (p == 0) begin
            count = 10'd512;
            code = RAM_CODE_64K;
            banked = 1'b1;
        end
        if (p == 1) begin
            count = 10'd1023;
            code = RAM_CODE_128K;
        end
        if (p == 2) begin
            count = 10'd2;
            code = RAM_CODE_NONE;
        end
        configure(kind, banked, count, code);
        // idle pattern per third of the run
        if (p < RANDOM_PHASES / 3) begin
            send_idle_pct = 13;
            recv_idle_pct = 87;
        end else if (p < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 87;
            recv_idle_pct = 13;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (p == 2 * RANDOM_PHASES / 3)
            squeeze_request = 1'b1;
        repeat (PHASE_ACCESSES) random_access();
    endtask

    // stimulus and end of run
    initial begin
        sb = new();
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_KIND;
        cfg_data = '0;
        s_valid = 1'b0;
        s_req_type = BUS_READ;
        s_address = '0;
        s_write_data = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 87;
        run_directed();
        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(p);
        settle();

        $display("run: %0d accesses over %0d bank setups, %0d results compared",
                 accesses_sent, bank_setups, sb.results_checked);
        $display("run: all kinds incl. spare codes, idle mixes and one long result stall");
        if (sb.errors == 0)
            $display("tb_cartridge_bank_controller: clean");
        else
            $display("tb_cartridge_bank_controller: errors");
        $finish;
    end

endmodule
